// ----- rtl/core/assert_macros.svh -----
// Assertion helpers for the cart-pole checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, quiet while reset is held.
`define CPDS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cart-pole check failed");

// Clocked check that also runs during reset.
`define CPDS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("cart-pole check failed");

`endif

// ----- rtl/core/cpds_pkg.sv -----
package cpds_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int QSH       = 30 - FRAC_BITS;

  localparam logic [31:0] TWO_PI_F    = 32'd411775;
  localparam logic [31:0] PI_F        = 32'd205887;
  localparam logic [31:0] HALF_PI_F   = 32'd102944;
  localparam logic [31:0] FOUR_THIRDS = 32'd87381;
  localparam logic [31:0] ANGLE_RESET = 32'd13107;
  localparam logic [33:0] CORDIC_GAIN = 34'd652032874;

  localparam logic [31:0] WMAX = 32'h7fff_ffff;
  localparam logic [31:0] WMIN = 32'h8000_0000;

  localparam logic [2:0] REG_TIME_STEP = 3'd0;
  localparam logic [2:0] REG_GRAVITY   = 3'd1;
  localparam logic [2:0] REG_FORCE     = 3'd2;
  localparam logic [2:0] REG_POLE_MASS = 3'd3;
  localparam logic [2:0] REG_LENGTH    = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RED, ST_FOLD, ST_CORD, ST_EXEC, ST_WB, ST_DIV, ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    OK_MUL, OK_ADD, OK_SUB, OK_NSUB, OK_DIV, OK_END
  } op_kind_t;

  typedef enum logic [4:0] {
    SR_RATE, SR_C1, SR_U, SR_G, SR_S, SR_C2, SR_W2, SR_T1, SR_T2, SR_CU, SR_C,
    SR_L, SR_K43, SR_NUM, SR_DEN, SR_THE2, SR_TAU, SR_VEL, SR_X2, SR_POS, SR_ANG
  } src_t;

  typedef enum logic [3:0] {
    DS_W2, DS_CU, DS_T1, DS_T2, DS_NUM, DS_DEN, DS_THE2, DS_X2,
    DS_POS, DS_VEL, DS_ANG, DS_RATE
  } dst_t;

  typedef struct packed {
    op_kind_t kind;
    src_t     a;
    src_t     b;
    dst_t     dst;
  } uop_t;

  function automatic uop_t uop_at(logic [4:0] pc);
    uop_t u;
    u = '{OK_END, SR_U, SR_U, DS_T1};
    case (pc)
      5'd0:  u = '{OK_MUL,  SR_RATE, SR_RATE, DS_W2};
      5'd1:  u = '{OK_MUL,  SR_C1,   SR_U,    DS_CU};
      5'd2:  u = '{OK_MUL,  SR_G,    SR_S,    DS_T1};
      5'd3:  u = '{OK_MUL,  SR_C2,   SR_W2,   DS_T2};
      5'd4:  u = '{OK_MUL,  SR_T2,   SR_S,    DS_T2};
      5'd5:  u = '{OK_NSUB, SR_CU,   SR_T2,   DS_T2};
      5'd6:  u = '{OK_MUL,  SR_C,    SR_T2,   DS_T2};
      5'd7:  u = '{OK_ADD,  SR_T1,   SR_T2,   DS_NUM};
      5'd8:  u = '{OK_MUL,  SR_L,    SR_K43,  DS_T1};
      5'd9:  u = '{OK_MUL,  SR_C2,   SR_C,    DS_T2};
      5'd10: u = '{OK_MUL,  SR_T2,   SR_C,    DS_T2};
      5'd11: u = '{OK_SUB,  SR_T1,   SR_T2,   DS_DEN};
      5'd12: u = '{OK_DIV,  SR_NUM,  SR_DEN,  DS_THE2};
      5'd13: u = '{OK_MUL,  SR_W2,   SR_S,    DS_T1};
      5'd14: u = '{OK_MUL,  SR_THE2, SR_C,    DS_T2};
      5'd15: u = '{OK_SUB,  SR_T1,   SR_T2,   DS_T1};
      5'd16: u = '{OK_MUL,  SR_C2,   SR_T1,   DS_T1};
      5'd17: u = '{OK_ADD,  SR_CU,   SR_T1,   DS_X2};
      5'd18: u = '{OK_MUL,  SR_TAU,  SR_VEL,  DS_T1};
      5'd19: u = '{OK_MUL,  SR_TAU,  SR_X2,   DS_T2};
      5'd20: u = '{OK_MUL,  SR_TAU,  SR_RATE, DS_NUM};
      5'd21: u = '{OK_MUL,  SR_TAU,  SR_THE2, DS_DEN};
      5'd22: u = '{OK_ADD,  SR_POS,  SR_T1,   DS_POS};
      5'd23: u = '{OK_ADD,  SR_VEL,  SR_T2,   DS_VEL};
      5'd24: u = '{OK_ADD,  SR_ANG,  SR_NUM,  DS_ANG};
      5'd25: u = '{OK_ADD,  SR_RATE, SR_DEN,  DS_RATE};
      default: u = '{OK_END, SR_U, SR_U, DS_T1};
    endcase
    return u;
  endfunction

  function automatic logic [33:0] atan_q30(logic [3:0] i);
    logic [33:0] v;
    v = 34'd0;
    case (i)
      4'd0:  v = 34'd843314857;
      4'd1:  v = 34'd497837829;
      4'd2:  v = 34'd263043837;
      4'd3:  v = 34'd133525159;
      4'd4:  v = 34'd67021687;
      4'd5:  v = 34'd33543516;
      4'd6:  v = 34'd16775851;
      4'd7:  v = 34'd8388437;
      4'd8:  v = 34'd4194283;
      4'd9:  v = 34'd2097149;
      4'd10: v = 34'd1048576;
      4'd11: v = 34'd524288;
      4'd12: v = 34'd262144;
      4'd13: v = 34'd131072;
      4'd14: v = 34'd65536;
      4'd15: v = 34'd32768;
      default: v = 34'd0;
    endcase
    return v;
  endfunction

  // Saturate a 34-bit signed sum to the word range.
  function automatic logic [32:0] sat34(logic signed [33:0] v);
    logic [32:0] r;
    if (v > $signed({2'b00, WMAX})) r = {1'b1, WMAX};
    else if (v < $signed({2'b11, WMIN})) r = {1'b1, WMIN};
    else r = {1'b0, v[31:0]};
    return r;
  endfunction

endpackage

// ----- rtl/core/cart_pole_dynamics_step_top.sv -----
// Cart-pole dynamics step: one explicit Euler step per force request.
// Input channel: in_valid / in_stall with in_force_req (signed Q15.16).
// Result channel: out_valid / out_stall with the updated cart position,
// cart velocity, pole angle, pole rate and a saturated flag.
// Configuration: APB-style port, register i at byte address 4*i
// (time_step, gravity, force_gain, pole_mass_term, pole_length); write only
// while no request is in flight. pready is tied high.
// Steps from acceptance to out_valid: 14 steps of angle reduction, 1 fold,
// 16 CORDIC iterations, 16 products on one shared 32x32 multiplier, 9 sums,
// a restoring divide (issue, 48 quotient bits one per cycle, write-back),
// then the end of the program and the load of the output register. in_stall
// is high while the sequencer runs, so a new request is taken only once the
// previous step has left the sequencer.
// The result sits in an output register; a stalled receiver holds it there
// and the block already accepts the next request. A finished step waits in
// the sequencer until the output register is free.
// Reset (synchronous, rst_n low) loads the default registers and the initial
// state: cart at rest at zero, pole at 0.2 rad, no result pending.
module cart_pole_dynamics_step_top import cpds_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_force_req,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_cart_position,
  output logic [31:0] out_cart_velocity,
  output logic [31:0] out_pole_angle,
  output logic [31:0] out_pole_rate,
  output logic        out_saturated,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  state_t state_r, state_nxt;
  logic [4:0]  pc_r, pc_nxt;
  logic [5:0]  cnt_r, cnt_nxt;

  logic [16:0] tau_r;
  logic [30:0] g_r, c1_r, c2_r, l_r;

  logic [31:0] pos_r, vel_r, ang_r, rate_r;
  logic [31:0] u_r, s_r, c_r, w2_r, cu_r, t1_r, t2_r, num_r, den_r, the2_r, x2_r;
  logic        sat_r;

  logic [31:0] m_r;
  logic        th_neg_r, neg_cos_r;
  logic [33:0] x_r, y_r, z_r;
  logic [63:0] prod_r;
  logic        mneg_r;
  logic [47:0] dq_r;
  logic [31:0] rem_r;
  logic        dneg_r;

  logic        out_valid_r;
  logic [31:0] o_pos_r, o_vel_r, o_ang_r, o_rate_r;
  logic        o_sat_r;

  // configuration port
  logic        cfg_wr;
  logic [2:0]  cfg_idx;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[4:2];

  always_comb begin
    case (cfg_idx)
      REG_TIME_STEP: cfg_prdata = {15'd0, tau_r};
      REG_GRAVITY:   cfg_prdata = {1'b0, g_r};
      REG_FORCE:     cfg_prdata = {1'b0, c1_r};
      REG_POLE_MASS: cfg_prdata = {1'b0, c2_r};
      REG_LENGTH:    cfg_prdata = {1'b0, l_r};
      default:       cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tau_r <= 17'd1092;
      g_r   <= 31'd642253;
      c1_r  <= 31'd32768;
      c2_r  <= 31'd32768;
      l_r   <= 31'd65536;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_TIME_STEP: tau_r <= cfg_pwdata[16:0];
        REG_GRAVITY:   g_r   <= cfg_pwdata[30:0];
        REG_FORCE:     c1_r  <= cfg_pwdata[30:0];
        REG_POLE_MASS: c2_r  <= cfg_pwdata[30:0];
        REG_LENGTH:    l_r   <= cfg_pwdata[30:0];
        default: ;
      endcase
    end
  end

  // micro-op and operand selection
  uop_t uop;
  assign uop = uop_at(pc_r);

  function automatic logic [31:0] pick(src_t sel, logic [31:0] rate, logic [31:0] c1,
      logic [31:0] u, logic [31:0] g, logic [31:0] s, logic [31:0] c2, logic [31:0] w2,
      logic [31:0] t1, logic [31:0] t2, logic [31:0] cu, logic [31:0] c, logic [31:0] l,
      logic [31:0] num, logic [31:0] den, logic [31:0] the2, logic [31:0] tau,
      logic [31:0] vel, logic [31:0] x2, logic [31:0] pos, logic [31:0] ang);
    logic [31:0] v;
    case (sel)
      SR_RATE: v = rate;
      SR_C1:   v = c1;
      SR_U:    v = u;
      SR_G:    v = g;
      SR_S:    v = s;
      SR_C2:   v = c2;
      SR_W2:   v = w2;
      SR_T1:   v = t1;
      SR_T2:   v = t2;
      SR_CU:   v = cu;
      SR_C:    v = c;
      SR_L:    v = l;
      SR_K43:  v = FOUR_THIRDS;
      SR_NUM:  v = num;
      SR_DEN:  v = den;
      SR_THE2: v = the2;
      SR_TAU:  v = tau;
      SR_VEL:  v = vel;
      SR_X2:   v = x2;
      SR_POS:  v = pos;
      SR_ANG:  v = ang;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  logic [31:0] opa, opb, maga, magb;
  assign opa = pick(uop.a, rate_r, {1'b0, c1_r}, u_r, {1'b0, g_r}, s_r, {1'b0, c2_r},
                    w2_r, t1_r, t2_r, cu_r, c_r, {1'b0, l_r}, num_r, den_r, the2_r,
                    {15'd0, tau_r}, vel_r, x2_r, pos_r, ang_r);
  assign opb = pick(uop.b, rate_r, {1'b0, c1_r}, u_r, {1'b0, g_r}, s_r, {1'b0, c2_r},
                    w2_r, t1_r, t2_r, cu_r, c_r, {1'b0, l_r}, num_r, den_r, the2_r,
                    {15'd0, tau_r}, vel_r, x2_r, pos_r, ang_r);
  assign maga = opa[31] ? (32'd0 - opa) : opa;
  assign magb = opb[31] ? (32'd0 - opb) : opb;

  // sum unit
  logic signed [33:0] sa, sb, sum;
  logic [32:0] sum_sat;
  assign sa = {{2{opa[31]}}, opa};
  assign sb = {{2{opb[31]}}, opb};
  always_comb begin
    case (uop.kind)
      OK_SUB:  sum = sa - sb;
      OK_NSUB: sum = -sa - sb;
      default: sum = sa + sb;
    endcase
  end
  assign sum_sat = sat34(sum);

  // product finish: drop fraction, saturate
  logic [31:0] rl, mlim, mres;
  logic        movf;
  assign rl   = prod_r[47:16];
  assign mlim = mneg_r ? WMIN : WMAX;
  assign movf = (|prod_r[63:48]) || (rl > mlim);
  assign mres = movf ? (mneg_r ? WMIN : WMAX) : (mneg_r ? (32'd0 - rl) : rl);

  // divider step
  logic [32:0] rem_sh;
  logic        dge;
  logic [31:0] rem_new;
  assign rem_sh  = {rem_r, dq_r[47]};
  assign dge     = rem_sh >= {1'b0, den_r};
  assign rem_new = dge ? 32'(rem_sh - {1'b0, den_r}) : rem_sh[31:0];

  logic [47:0] dlim;
  logic        dovf;
  logic [31:0] dres;
  assign dlim = {16'd0, dneg_r ? WMIN : WMAX};
  assign dovf = dq_r > dlim;
  assign dres = dovf ? (dneg_r ? WMIN : WMAX) : (dneg_r ? (32'd0 - dq_r[31:0]) : dq_r[31:0]);

  // angle reduction step
  logic [31:0] red_sub;
  logic [45:0] red_cmp;
  assign red_cmp = {14'd0, TWO_PI_F} << cnt_r[3:0];
  assign red_sub = red_cmp[31:0];

  logic signed [31:0] r0, r1, r2;
  logic               fold_neg;
  always_comb begin
    r0 = (th_neg_r && (m_r != 32'd0)) ? $signed(TWO_PI_F - m_r) : $signed(m_r);
    r1 = (r0 > $signed(PI_F)) ? (r0 - $signed(TWO_PI_F)) : r0;
    fold_neg = 1'b0;
    r2 = r1;
    if (r1 > $signed(HALF_PI_F)) begin
      r2 = $signed(PI_F) - r1;
      fold_neg = 1'b1;
    end else if (r1 < -$signed(HALF_PI_F)) begin
      r2 = -$signed(PI_F) - r1;
      fold_neg = 1'b1;
    end
  end

  // CORDIC shifts
  logic signed [33:0] xs, ys, atn;
  assign xs  = $signed(x_r) >>> cnt_r[3:0];
  assign ys  = $signed(y_r) >>> cnt_r[3:0];
  assign atn = $signed(atan_q30(cnt_r[3:0]));

  logic signed [33:0] sfin, cfin;
  assign sfin = $signed(y_r) >>> QSH;
  assign cfin = $signed(x_r) >>> QSH;

  logic out_free;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_RED;
          cnt_nxt   = 6'd13;
        end
      end
      ST_RED: begin
        if (cnt_r == 6'd0) state_nxt = ST_FOLD;
        else cnt_nxt = cnt_r - 6'd1;
      end
      ST_FOLD: begin
        state_nxt = ST_CORD;
        cnt_nxt   = 6'd0;
      end
      ST_CORD: begin
        if (cnt_r == 6'd15) begin
          state_nxt = ST_EXEC;
          pc_nxt    = 5'd0;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      ST_EXEC: begin
        case (uop.kind)
          OK_MUL: state_nxt = ST_WB;
          OK_DIV: begin
            if ($signed(den_r) > 0) begin
              state_nxt = ST_DIV;
              cnt_nxt   = 6'd0;
            end else begin
              pc_nxt = pc_r + 5'd1;
            end
          end
          OK_END: state_nxt = ST_OUT;
          default: pc_nxt = pc_r + 5'd1;
        endcase
      end
      ST_WB: begin
        state_nxt = ST_EXEC;
        pc_nxt    = pc_r + 5'd1;
      end
      ST_DIV: begin
        // the final count writes back the quotient
        if (cnt_r == 6'd48) begin
          state_nxt = ST_EXEC;
          pc_nxt    = pc_r + 5'd1;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pc_r    <= 5'd0;
      cnt_r   <= 6'd0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // datapath
  logic [31:0] wr_val;
  logic        wr_en, wr_sat;
  always_comb begin
    wr_en  = 1'b0;
    wr_sat = 1'b0;
    wr_val = sum_sat[31:0];
    if (state_r == ST_WB) begin
      wr_en  = 1'b1;
      wr_val = mres;
      wr_sat = movf;
    end else if (state_r == ST_DIV && cnt_r == 6'd48) begin
      wr_en  = 1'b1;
      wr_val = dres;
      wr_sat = dovf;
    end else if (state_r == ST_EXEC) begin
      case (uop.kind)
        OK_ADD, OK_SUB, OK_NSUB: begin
          wr_en  = 1'b1;
          wr_sat = sum_sat[32];
        end
        OK_DIV: begin
          if (!($signed(den_r) > 0)) begin
            wr_en  = 1'b1;
            wr_val = 32'd0;
            wr_sat = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= 32'd0;
      vel_r  <= 32'd0;
      ang_r  <= ANGLE_RESET;
      rate_r <= 32'd0;
    end else begin
      if (wr_en) begin
        case (uop.dst)
          DS_POS:  pos_r  <= wr_val;
          DS_VEL:  vel_r  <= wr_val;
          DS_ANG:  ang_r  <= wr_val;
          DS_RATE: rate_r <= wr_val;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      u_r      <= in_force_req;
      sat_r    <= 1'b0;
      th_neg_r <= ang_r[31];
      m_r      <= ang_r[31] ? (32'd0 - ang_r) : ang_r;
    end
    if (state_r == ST_RED && m_r >= red_sub && red_cmp[45:32] == 14'd0) begin
      m_r <= m_r - red_sub;
    end
    if (state_r == ST_FOLD) begin
      neg_cos_r <= fold_neg;
      x_r <= CORDIC_GAIN;
      y_r <= 34'd0;
      z_r <= 34'({{2{r2[31]}}, r2} <<< QSH);
    end
    if (state_r == ST_CORD) begin
      if (!z_r[33]) begin
        x_r <= 34'($signed(x_r) - ys);
        y_r <= 34'($signed(y_r) + xs);
        z_r <= 34'($signed(z_r) - atn);
      end else begin
        x_r <= 34'($signed(x_r) + ys);
        y_r <= 34'($signed(y_r) - xs);
        z_r <= 34'($signed(z_r) + atn);
      end
    end
    if (state_r == ST_EXEC && pc_r == 5'd0) begin
      s_r <= sfin[31:0];
      c_r <= neg_cos_r ? (32'd0 - cfin[31:0]) : cfin[31:0];
    end
    if (state_r == ST_EXEC && uop.kind == OK_MUL) begin
      prod_r <= maga * magb;
      mneg_r <= opa[31] != opb[31];
    end
    if (state_r == ST_EXEC && uop.kind == OK_DIV) begin
      dq_r   <= {maga, 16'd0};
      rem_r  <= 32'd0;
      dneg_r <= opa[31];
    end
    if (state_r == ST_DIV && cnt_r != 6'd48) begin
      dq_r  <= {dq_r[46:0], dge};
      rem_r <= rem_new;
    end
    if (wr_en) begin
      if (wr_sat) sat_r <= 1'b1;
      case (uop.dst)
        DS_W2:   w2_r   <= wr_val;
        DS_CU:   cu_r   <= wr_val;
        DS_T1:   t1_r   <= wr_val;
        DS_T2:   t2_r   <= wr_val;
        DS_NUM:  num_r  <= wr_val;
        DS_DEN:  den_r  <= wr_val;
        DS_THE2: the2_r <= wr_val;
        DS_X2:   x2_r   <= wr_val;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && out_free) begin
      o_pos_r  <= pos_r;
      o_vel_r  <= vel_r;
      o_ang_r  <= ang_r;
      o_rate_r <= rate_r;
      o_sat_r  <= sat_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cart_position = o_pos_r;
  assign out_cart_velocity = o_vel_r;
  assign out_pole_angle    = o_ang_r;
  assign out_pole_rate     = o_rate_r;
  assign out_saturated     = o_sat_r;

endmodule

// ----- rtl/core/cpds_checker.sv -----
`include "assert_macros.svh"

module cpds_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_cart_position,
  input logic        cfg_pready
);

  // a stalled result holds its value
  `CPDS_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_cart_position))
  // the sequencer is busy right after it takes a request
  `CPDS_ASSERT(a_busy_after_req, clk, rst_n, in_valid && !in_stall |=> in_stall)
  // no result can appear the cycle after a request is taken
  `CPDS_ASSERT(a_no_instant_result, clk, rst_n, in_valid && !in_stall |=> !$rose(out_valid))
  // the register port never waits
  `CPDS_ASSERT_ALWAYS(a_pready, clk, cfg_pready)

endmodule

bind cart_pole_dynamics_step_top cpds_checker u_cpds_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_cart_position (out_cart_position),
  .cfg_pready        (cfg_pready)
);
